/* src/fba_pkg.sv */
package fba_pkg;

	localparam int WORD_BITS = 32;
	localparam int MAX_FRAMES = 4096;
	localparam int DEPTH = MAX_FRAMES / WORD_BITS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int WCNT_W = ADDR_W + 1;
	localparam int FRAME_W = 12;
	localparam int CNT_W = 13;

	localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 13'h1000;
	localparam logic [WORD_BITS-1:0] FULL_WORD = '1;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_ALLOC = 2'd0;
	localparam logic [1:0] STAT_HELD = 2'd1;
	localparam logic [1:0] STAT_OOF = 2'd2;
	localparam logic [1:0] STAT_FREED = 2'd3;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic en;
		addr_t addr;
	} mem_rd_t;

	typedef struct packed {
		logic en;
		addr_t addr;
		word_t data;
	} mem_wr_t;

	// position of the lowest clear bit; caller checks the word is not full
	function automatic logic [BIT_W-1:0] lowest_zero(word_t w);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				pos = BIT_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

/* src/fba_bitmap_mem.sv */
module fba_bitmap_mem (
	input  logic            clk,
	input  logic            arst_n,
	input  fba_pkg::mem_rd_t rd,
	output fba_pkg::word_t  rd_data,
	input  fba_pkg::mem_wr_t wr
);
	import fba_pkg::*;

	word_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	word_t raw_s1;
	logic rvalid_s1;

	// storage array, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			raw_s1 <= mem[rd.addr];
		end
	end

	// per-word written flags; an unwritten word reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rvalid_s1 <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = rvalid_s1 ? raw_s1 : '0;

endmodule

/* src/frame_bitmap_allocator_unit.sv */
// Channel   Dir  Handshake          Payload
// in        in   in_valid/in_stall  command, entry_frame, kernel_page, is_writable
// out       out  out_valid/out_stall status, new_frame, present, read_write, user_page
// cfg       in   cfg_valid/cfg_ready cfg_data (frame_count)
//
// One request at a time. Held entry or free of nothing: the result state, then the
// output register; free: bitmap read, then write-back (read-modify-write); allocate:
// scan from word 0 to the first word with a free frame, one bitmap word per cycle
// through the memory read port, over at most 128 words.
// Reset clears the per-word written flags at once; no clearing pass.
// A stalled output holds the finished result and blocks the next request.
module frame_bitmap_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [fba_pkg::FRAME_W-1:0]   entry_frame,
	input  logic                          kernel_page,
	input  logic                          is_writable,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [fba_pkg::FRAME_W-1:0]   new_frame,
	output logic                          present,
	output logic                          read_write,
	output logic                          user_page,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fba_pkg::CNT_W-1:0]     cfg_data
);
	import fba_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FREE = 2'd2;
	localparam logic [1:0] ST_RES = 2'd3;

	logic [1:0] state_q;
	logic [CNT_W-1:0] frame_count_q;
	logic [WCNT_W-1:0] words_q;
	logic [WCNT_W-1:0] words_w;
	logic [WCNT_W-1:0] next_idx;
	addr_t chk_idx_q;
	logic [BIT_W-1:0] bit_q;
	logic kernel_q;
	logic writable_q;
	logic [BIT_W-1:0] zero_pos;

	logic [1:0] res_status_q;
	logic [FRAME_W-1:0] res_frame_q;
	logic res_present_q;
	logic res_rw_q;
	logic res_user_q;

	mem_rd_t rd;
	mem_wr_t wr;
	word_t rd_data;
	logic in_acc;

	fba_bitmap_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.rd_data (rd_data),
		.wr      (wr)
	);

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;

	// searched word count, clamped to the bitmap depth
	assign words_w = (frame_count_q[CNT_W-1:BIT_W] > WCNT_W'(DEPTH))
		? WCNT_W'(DEPTH) : WCNT_W'(frame_count_q[CNT_W-1:BIT_W]);
	assign next_idx = {1'b0, chk_idx_q} + WCNT_W'(1);
	assign zero_pos = lowest_zero(rd_data);

	// memory port control
	always_comb begin
		rd.en = 1'b0;
		rd.addr = '0;
		wr.en = 1'b0;
		wr.addr = chk_idx_q;
		wr.data = rd_data;
		case (state_q)
			ST_IDLE: begin
				rd.en = in_acc;
				rd.addr = (command == CMD_FREE) ? entry_frame[FRAME_W-1:BIT_W] : '0;
			end
			ST_SCAN: begin
				rd.en = 1'b1;
				rd.addr = next_idx[ADDR_W-1:0];
				wr.en = (rd_data != FULL_WORD);
				wr.data = rd_data | (word_t'(1) << zero_pos);
			end
			ST_FREE: begin
				wr.en = 1'b1;
				wr.data = rd_data & ~(word_t'(1) << bit_q);
			end
			default: begin
			end
		endcase
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			frame_count_q <= cfg_data;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (command == CMD_FREE) begin
							state_q <= (entry_frame != '0) ? ST_FREE : ST_RES;
						end else if (entry_frame != '0 || words_w == '0) begin
							state_q <= ST_RES;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_data != FULL_WORD || next_idx == words_q) begin
						state_q <= ST_RES;
					end
				end
				ST_FREE: state_q <= ST_RES;
				ST_RES: begin
					if (!out_valid || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request context and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				words_q <= words_w;
				// free writes back the word of the entry's frame
				chk_idx_q <= (command == CMD_FREE) ? entry_frame[FRAME_W-1:BIT_W] : '0;
				bit_q <= entry_frame[BIT_W-1:0];
				kernel_q <= kernel_page;
				writable_q <= is_writable;
				res_present_q <= 1'b0;
				res_rw_q <= 1'b0;
				res_user_q <= 1'b0;
				res_frame_q <= '0;
				if (command == CMD_FREE) begin
					res_status_q <= STAT_FREED;
				end else if (entry_frame != '0) begin
					res_status_q <= STAT_HELD;
					res_frame_q <= entry_frame;
				end else begin
					res_status_q <= STAT_OOF;
				end
			end
			ST_SCAN: begin
				chk_idx_q <= next_idx[ADDR_W-1:0];
				if (rd_data != FULL_WORD) begin
					res_status_q <= STAT_ALLOC;
					res_frame_q <= FRAME_W'({chk_idx_q, zero_pos});
					res_present_q <= 1'b1;
					res_rw_q <= writable_q;
					res_user_q <= !kernel_q;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_RES && (!out_valid || !out_stall)) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RES && (!out_valid || !out_stall)) begin
			status <= res_status_q;
			new_frame <= res_frame_q;
			present <= res_present_q;
			read_write <= res_rw_q;
			user_page <= res_user_q;
		end
	end

	// checks
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (words_q != '0 && {1'b0, chk_idx_q} < words_q))
		else $error("scan index past searched words");

	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_SCAN || state_q == ST_FREE))
		else $error("bitmap write outside scan or free");

	a_alloc_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RES && res_status_q == STAT_ALLOC) |-> res_present_q)
		else $error("allocation result without present bit");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != ST_IDLE))
		else $error("sequencer idle after accepting a request");

endmodule
